FILE: rtl/canonical_kmer_minimizer_unit_assert.svh
// assertion macros for the canonical k-mer minimizer unit checker
// no dependencies; included by the checker file
`ifndef CANONICAL_KMER_MINIMIZER_UNIT_ASSERT_SVH
`define CANONICAL_KMER_MINIMIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define CKM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ckm_pkg.sv
// shared types, constants and helper functions of the canonical k-mer minimizer
// no dependencies; used by every rtl file but the assertion header
package ckm_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = IDX_W + 1;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 32;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  localparam logic [CFG_W-1:0] KMER_LENGTH_RESET   = 5'd15;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 5'd10;
  localparam logic [CFG_W-1:0] KMER_MAX            = 5'd16;
  localparam logic [CFG_W-1:0] WINDOW_MAX          = CFG_W'(MAX_WINDOW);

  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef struct packed {
    logic [7:0] base_char;
    logic       end_of_sequence;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] minimizer_value;
    logic [POS_W-1:0] kmer_position;
    logic             forward_strand;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic             fwd;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] count;
  } scan_req_t;

  typedef struct packed {
    logic   done;
    entry_t best;
  } scan_res_t;

  function automatic logic [1:0] encode_base(input logic [7:0] ch);
    logic [1:0] code;
    case (ch)
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_len(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/canonical_kmer_minimizer_unit.sv
// canonical k-mer window minimizer: one base per word, at most one minimizer word out.
// a base that completes no window needs no scan; one that needs a window minimum starts a scan
// of n entries (n up to 16) in the one-port window memory, which is read one entry a cycle.
// next base is taken once the minimum word is loaded into the output or dropped as a repeat.
// reset (rst, synchronous): kmer_length 15, window_length 10, sequence state cleared;
// window memory keeps its contents and needs no clearing pass.
module canonical_kmer_minimizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ckm_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ckm_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [ckm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckm_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [ckm_pkg::CFG_W-1:0]   kmer_length;
  logic [ckm_pkg::CFG_W-1:0]   window_length;
  logic [ckm_pkg::VAL_W-1:0]   forward_kmer;
  logic [ckm_pkg::VAL_W-1:0]   revcomp_kmer;
  logic [ckm_pkg::IDX_W-1:0]   wr_idx;
  logic [ckm_pkg::POS_W-1:0]   bases_seen;
  logic [ckm_pkg::CNT_W-1:0]   kmers_seen;
  logic [ckm_pkg::POS_W-1:0]   last_pos;
  logic                        last_valid;
  logic                        eos_pend;
  ckm_pkg::entry_t             best;

  logic [ckm_pkg::CFG_W-1:0]   k;
  logic [ckm_pkg::CFG_W-1:0]   w;
  logic [1:0]                  code;
  logic [5:0]                  shamt;
  logic [ckm_pkg::VAL_W-1:0]   mask;
  logic [ckm_pkg::VAL_W-1:0]   fwd_next;
  logic [ckm_pkg::VAL_W-1:0]   rev_next;
  logic [ckm_pkg::POS_W-1:0]   bases_inc;
  logic                        form;
  logic [ckm_pkg::CNT_W-1:0]   kmers_inc;
  logic [ckm_pkg::IDX_W-1:0]   wr_idx_inc;
  logic                        scan_full;
  logic                        scan_short;
  logic [ckm_pkg::CNT_W-1:0]   scan_cnt;
  ckm_pkg::entry_t             new_entry;
  logic                        accept;
  logic                        dup;
  logic                        out_free;
  logic                        emit;
  logic                        finish;
  logic                        clear_seq;

  ckm_pkg::mem_wr_t            mem_wr;
  ckm_pkg::scan_req_t          scan_req;
  ckm_pkg::scan_res_t          scan_res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    k          = ckm_pkg::clamp_len(kmer_length, ckm_pkg::KMER_MAX);
    w          = ckm_pkg::clamp_len(window_length, ckm_pkg::WINDOW_MAX);
    code       = ckm_pkg::encode_base(in_data.base_char);
    shamt      = {k, 1'b0};
    // a shift by the full width yields zero, so k = 16 gives all ones
    mask       = ~({ckm_pkg::VAL_W{1'b1}} << shamt);
    fwd_next   = {forward_kmer[ckm_pkg::VAL_W-3:0], code} & mask;
    rev_next   = ((revcomp_kmer >> 2) |
                  ({{(ckm_pkg::VAL_W-2){1'b0}}, ~code} << (shamt - 6'd2))) & mask;
    bases_inc  = bases_seen + ckm_pkg::POS_W'(1);
    form       = (bases_inc >= ckm_pkg::POS_W'(k)) || (kmers_seen != '0);
    if (!form) begin
      kmers_inc = kmers_seen;
    end else if (kmers_seen == ckm_pkg::CNT_W'(ckm_pkg::MAX_WINDOW)) begin
      kmers_inc = kmers_seen;
    end else begin
      kmers_inc = kmers_seen + ckm_pkg::CNT_W'(1);
    end
    wr_idx_inc = form ? wr_idx + ckm_pkg::IDX_W'(1) : wr_idx;
    scan_full  = form && (kmers_inc >= w);
    scan_short = in_data.end_of_sequence && (kmers_inc != '0) && (kmers_inc < w);
    scan_cnt   = scan_full ? w : kmers_inc;
    if (fwd_next <= rev_next) begin
      new_entry.value = fwd_next;
      new_entry.fwd   = 1'b1;
    end else begin
      new_entry.value = rev_next;
      new_entry.fwd   = 1'b0;
    end
    new_entry.pos = bases_inc - ckm_pkg::POS_W'(k);
  end

  always_comb begin
    mem_wr.en      = accept && form;
    mem_wr.addr    = wr_idx;
    mem_wr.data    = new_entry;
    scan_req.start = accept && (scan_full || scan_short);
    // window of 16 wraps to the write index itself
    scan_req.base  = wr_idx_inc - scan_cnt[ckm_pkg::IDX_W-1:0];
    scan_req.count = scan_cnt;
  end

  ckm_window_scan u_scan (
    .clk (clk),
    .rst (rst),
    .wr  (mem_wr),
    .req (scan_req),
    .res (scan_res)
  );

  assign dup      = last_valid && (last_pos == best.pos);
  assign out_free = !out_valid || out_ready;
  assign emit     = (state == S_EMIT) && !dup && out_free;
  assign finish   = (state == S_EMIT) && (dup || out_free);
  assign clear_seq = (accept && in_data.end_of_sequence && !scan_req.start) ||
                     (finish && eos_pend);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (scan_req.start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kmer_length   <= ckm_pkg::KMER_LENGTH_RESET;
      window_length <= ckm_pkg::WINDOW_LENGTH_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          ckm_pkg::REG_KMER_LENGTH:   kmer_length   <= cfg_data;
          ckm_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst || clear_seq) begin
      forward_kmer <= '0;
      revcomp_kmer <= '0;
      wr_idx       <= '0;
      bases_seen   <= '0;
      kmers_seen   <= '0;
      last_pos     <= '0;
      last_valid   <= 1'b0;
    end else begin
      if (accept) begin
        forward_kmer <= fwd_next;
        revcomp_kmer <= rev_next;
        wr_idx       <= wr_idx_inc;
        bases_seen   <= bases_inc;
        kmers_seen   <= kmers_inc;
      end
      if (emit) begin
        last_pos   <= best.pos;
        last_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eos_pend <= in_data.end_of_sequence;
    end
    if (state == S_SCAN && scan_res.done) begin
      best <= scan_res.best;
    end
    if (emit) begin
      out_data.minimizer_value <= best.value;
      out_data.kmer_position   <= best.pos;
      out_data.forward_strand  <= best.fwd;
    end
  end

endmodule

FILE: rtl/ckm_window_scan.sv
// window store memory and the min-scan engine that walks it one entry a cycle
// depends on ckm_pkg
module ckm_window_scan (
  input  logic               clk,
  input  logic               rst,
  input  ckm_pkg::mem_wr_t   wr,
  input  ckm_pkg::scan_req_t req,
  output ckm_pkg::scan_res_t res
);

  ckm_pkg::entry_t mem [ckm_pkg::MAX_WINDOW];

  logic                      busy;
  logic                      first_pend;
  logic [ckm_pkg::IDX_W-1:0] rd_addr;
  logic [ckm_pkg::CNT_W-1:0] remain;
  logic                      rd_valid;
  logic                      rd_first;
  logic                      rd_last;
  logic                      done;
  ckm_pkg::entry_t           rd_q;
  ckm_pkg::entry_t           best;

  // single port: writes only come in while the scan is idle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end else if (busy) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= busy;
      done     <= rd_valid && rd_last;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && remain == ckm_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rd_addr    <= req.base;
      remain     <= req.count;
      first_pend <= 1'b1;
    end else if (busy) begin
      rd_addr    <= rd_addr + ckm_pkg::IDX_W'(1);
      remain     <= remain - ckm_pkg::CNT_W'(1);
      first_pend <= 1'b0;
      rd_first   <= first_pend;
      rd_last    <= (remain == ckm_pkg::CNT_W'(1));
    end
  end

  // strict less-than keeps the oldest entry on ties
  always_ff @(posedge clk) begin
    if (rd_valid && (rd_first || rd_q.value < best.value)) begin
      best <= rd_q;
    end
  end

  assign res.done = done;
  assign res.best = best;

endmodule

FILE: rtl/ckm_checker.sv
// port-level checker for the canonical k-mer minimizer unit, bound to the top level
// depends on ckm_pkg and canonical_kmer_minimizer_unit_assert.svh
`include "canonical_kmer_minimizer_unit_assert.svh"

module ckm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ckm_pkg::out_word_t out_data
);

  // a waiting word holds until taken
  `CKM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed or dropped while stalled")

  // no word comes out right after reset
  `CKM_ASSERT_NOW(a_out_reset, clk, rst, $past(rst), !out_valid, "output valid right after reset")

  // a new word only appears at the end of a scan, while input is held off
  `CKM_ASSERT_NOW(a_out_after_scan, clk, rst, $rose(out_valid), $past(!in_ready), "output word appeared while input was open")

endmodule

bind canonical_kmer_minimizer_unit ckm_checker u_ckm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/testbench.sv
// testbench for canonical_kmer_minimizer_unit: directed and random base streams
// every minimizer word is checked against an in-bench predictor of the window minimum
// depends on rtl/ckm_pkg.sv and rtl/canonical_kmer_minimizer_unit.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] CHAR_A = 8'h41;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  ckm_pkg::in_word_t             in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ckm_pkg::out_word_t            out_data;
  logic                          cfg_we = 1'b0;
  logic [ckm_pkg::CFG_IDX_W-1:0] cfg_index = ckm_pkg::REG_KMER_LENGTH;
  logic [ckm_pkg::CFG_W-1:0]     cfg_data = '0;

  canonical_kmer_minimizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and per-sequence state of the predictor
  logic [ckm_pkg::CFG_W-1:0] kmer_len_reg = ckm_pkg::KMER_LENGTH_RESET;
  logic [ckm_pkg::CFG_W-1:0] window_len_reg = ckm_pkg::WINDOW_LENGTH_RESET;
  logic [31:0]               fwd_word;
  logic [31:0]               rc_word;
  ckm_pkg::entry_t           kmer_ring [ckm_pkg::MAX_WINDOW];
  logic [ckm_pkg::IDX_W-1:0] ring_wr;
  logic [31:0]               base_count;
  logic [31:0]               kmer_count;
  logic [31:0]               last_pos;
  logic                      last_pos_valid;

  ckm_pkg::out_word_t expected_minimizers [$];
  int                 mismatch_count = 0;
  bit                 no_gaps = 1'b0;

  function automatic void clear_sequence();
    fwd_word = '0;
    rc_word = '0;
    ring_wr = '0;
    base_count = '0;
    kmer_count = '0;
    last_pos = '0;
    last_pos_valid = 1'b0;
  endfunction

  function automatic int unsigned eff_len(input logic [ckm_pkg::CFG_W-1:0] v,
                                          input logic [ckm_pkg::CFG_W-1:0] hi);
    if (v == '0) return 1;
    if (v > hi) return 32'(hi);
    return 32'(v);
  endfunction

  // oldest entry wins a tie, so only a strictly smaller value replaces it
  function automatic ckm_pkg::entry_t window_min(input int unsigned n);
    ckm_pkg::entry_t           best;
    logic [ckm_pkg::IDX_W-1:0] idx;
    idx = ring_wr - ckm_pkg::IDX_W'(n);
    best = kmer_ring[idx];
    for (int j = 1; j < n; j++) begin
      idx = idx + ckm_pkg::IDX_W'(1);
      if (kmer_ring[idx].value < best.value) best = kmer_ring[idx];
    end
    return best;
  endfunction

  function automatic void note_minimizer(input ckm_pkg::entry_t e);
    ckm_pkg::out_word_t o;
    if (last_pos_valid && last_pos == e.pos) return;
    last_pos = e.pos;
    last_pos_valid = 1'b1;
    o.minimizer_value = e.value;
    o.kmer_position = e.pos;
    o.forward_strand = e.fwd;
    expected_minimizers.insert(expected_minimizers.size(), o);
  endfunction

  function automatic void predict_minimizer(input ckm_pkg::in_word_t wd);
    int unsigned     k;
    int unsigned     w;
    logic [1:0]      code;
    logic [1:0]      comp;
    logic [31:0]     mask;
    ckm_pkg::entry_t cand;
    k = eff_len(kmer_len_reg, ckm_pkg::KMER_MAX);
    w = eff_len(window_len_reg, ckm_pkg::WINDOW_MAX);
    case (wd.base_char)
      ckm_pkg::CHAR_C: code = ckm_pkg::CODE_C;
      ckm_pkg::CHAR_G: code = ckm_pkg::CODE_G;
      ckm_pkg::CHAR_T: code = ckm_pkg::CODE_T;
      default:         code = ckm_pkg::CODE_A;
    endcase
    comp = ~code;
    mask = (k == 16) ? 32'hFFFF_FFFF : ((32'd1 << (2 * k)) - 32'd1);
    fwd_word = ((fwd_word << 2) | {30'd0, code}) & mask;
    rc_word = ((rc_word >> 2) | ({30'd0, comp} << (2 * (k - 1)))) & mask;
    base_count = base_count + 32'd1;
    if (base_count >= k || kmer_count != '0) begin
      if (fwd_word <= rc_word) begin
        cand.value = fwd_word;
        cand.fwd = 1'b1;
      end else begin
        cand.value = rc_word;
        cand.fwd = 1'b0;
      end
      cand.pos = base_count - k;
      kmer_ring[ring_wr] = cand;
      ring_wr = ring_wr + ckm_pkg::IDX_W'(1);
      if (kmer_count != '1) kmer_count = kmer_count + 32'd1;
      if (kmer_count >= w) note_minimizer(window_min(w));
    end
    if (wd.end_of_sequence) begin
      // sequence too short to fill one window reports its overall minimum
      if (kmer_count != '0 && kmer_count < w) note_minimizer(window_min(kmer_count));
      clear_sequence();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] pick_base();
    if ($urandom_range(0, 99) < 88) begin
      case ($urandom_range(0, 3))
        0: return CHAR_A;
        1: return ckm_pkg::CHAR_C;
        2: return ckm_pkg::CHAR_G;
        default: return ckm_pkg::CHAR_T;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ckm_pkg::CFG_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? ckm_pkg::CFG_W'(0) :
                                       ckm_pkg::CFG_W'($urandom_range(17, 31));
      1: return ckm_pkg::KMER_MAX;
      2, 3: return ckm_pkg::CFG_W'($urandom_range(7, 15));
      default: return ckm_pkg::CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int pick_seq_len();
    int k;
    int w;
    int r;
    k = int'(eff_len(kmer_len_reg, ckm_pkg::KMER_MAX));
    w = int'(eff_len(window_len_reg, ckm_pkg::WINDOW_MAX));
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(1, k);
    if (r == 1) return k + $urandom_range(0, w - 1);
    return k + w - 1 + $urandom_range(0, 24);
  endfunction

  // result side: random stalls on out_ready
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ckm_pkg::out_word_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (expected_minimizers.size() == 0) begin
        $display("%0t: expected no word, actual value %h position %h strand %b", $time,
                 out_data.minimizer_value, out_data.kmer_position, out_data.forward_strand);
        mismatch_count++;
      end else begin
        exp_word = expected_minimizers.pop_front();
        if (out_data.minimizer_value !== exp_word.minimizer_value) begin
          $display("%0t: minimizer_value expected %h actual %h", $time,
                   exp_word.minimizer_value, out_data.minimizer_value);
          mismatch_count++;
        end
        if (out_data.kmer_position !== exp_word.kmer_position) begin
          $display("%0t: kmer_position expected %h actual %h", $time,
                   exp_word.kmer_position, out_data.kmer_position);
          mismatch_count++;
        end
        if (out_data.forward_strand !== exp_word.forward_strand) begin
          $display("%0t: forward_strand expected %b actual %b", $time,
                   exp_word.forward_strand, out_data.forward_strand);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] ch, input logic eos);
    ckm_pkg::in_word_t wd;
    int                gap;
    wd.base_char = ch;
    wd.end_of_sequence = eos;
    in_valid <= 1'b1;
    in_data <= wd;
    do @(posedge clk); while (!in_ready);
    predict_minimizer(wd);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send_word(s[i], close && i == s.len() - 1);
  endtask

  // wait for outstanding words, then for a base that may still be scanning
  task automatic wait_quiet();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_minimizers.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_minimizers.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_minimizers.size());
      mismatch_count++;
      expected_minimizers.delete();
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic set_lengths(input logic [ckm_pkg::CFG_W-1:0] k,
                             input logic [ckm_pkg::CFG_W-1:0] w);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_index <= ckm_pkg::REG_KMER_LENGTH;
    cfg_data <= k;
    @(posedge clk);
    kmer_len_reg = k;
    cfg_index <= ckm_pkg::REG_WINDOW_LENGTH;
    cfg_data <= w;
    @(posedge clk);
    window_len_reg = w;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one k-mer under the reset lengths, reported by the short-sequence rule
  task automatic test_reset_lengths();
    send_string("GATTACAGATTACAG", 1'b1);
  endtask

  // lowercase and other bytes count as A
  task automatic test_base_codes();
    set_lengths(5'd1, 5'd1);
    send_string("ACGTa", 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_length_clamp();
    set_lengths(5'd0, 5'd0);
    send_string("GTC", 1'b1);
    // clamps to 16 and 16, so this sequence is too short for any k-mer
    set_lengths(5'd31, 5'd31);
    send_string("ACG", 1'b1);
  endtask

  // palindromic k-mers tie on both strands; lengths change inside the sequence
  task automatic test_midsequence_change();
    set_lengths(5'd2, 5'd3);
    send_string("ATATA", 1'b0);
    set_lengths(5'd3, 5'd1);
    send_string("CCG", 1'b1);
  endtask

  task automatic test_random_sequences();
    int made;
    int len;
    int split;
    int seqs;
    made = 0;
    while (made < 1250) begin
      set_lengths(pick_len(), pick_len());
      no_gaps = ($urandom_range(0, 3) == 0);
      seqs = $urandom_range(2, 6);
      for (int s = 0; s < seqs && made < 1250; s++) begin
        len = pick_seq_len();
        split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == split) set_lengths(pick_len(), pick_len());
          send_word(pick_base(), i == len - 1);
          made++;
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clear_sequence();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_lengths();
    test_base_codes();
    test_length_clamp();
    test_midsequence_change();
    test_random_sequences();
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ckm_pkg.sv
rtl/ckm_window_scan.sv
rtl/canonical_kmer_minimizer_unit.sv
rtl/ckm_checker.sv
dv/testbench.sv
